@@ src/ltc_pkg.sv @@
//------------------------------------------------------------------------------
// ltc_pkg
// Shared types, widths and helpers for the layered tint compositor.
//------------------------------------------------------------------------------
`default_nettype none

package ltc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int PCT_W  = 7;
    localparam int CHAN_W = 8;
    localparam int P_W    = 15;
    localparam int A2_W   = FRAC_BITS + 1;
    localparam int Q_W    = FRAC_BITS + 1;
    localparam int COL_W  = CHAN_W + FRAC_BITS;
    localparam int D_W    = COL_W + 1;
    localparam int ACC_W  = D_W + FRAC_BITS + 1;
    localparam int CNT_W  = $clog2(A2_W + 1);
    localparam int OUT_W  = 16;
    localparam int Q16_W  = CHAN_W + OUT_W;

    localparam int SCALE_DEN = 25500;
    localparam int RECIP_SH  = 16;
    localparam int RECIP_W   = FRAC_BITS + 3;
    localparam int EMUL_W    = P_W + RECIP_W;
    localparam int QM_W      = Q_W + P_W;

    localparam logic [RECIP_W-1:0] SCALE_RECIP =
        RECIP_W'((64'd1 << (FRAC_BITS + RECIP_SH)) / 64'd25500);

    localparam logic [A2_W-1:0] ONE_FX = A2_W'(1) << FRAC_BITS;

    localparam logic [PCT_W-1:0] PCT_RESET = PCT_W'(100);

    localparam int CHAN_MAX = 255;
    localparam int OUT_MAX  = 65535;

    localparam int SH_UP = (FRAC_BITS < 16) ? (16 - FRAC_BITS) : 0;
    localparam int SH_DN = (FRAC_BITS > 16) ? (FRAC_BITS - 16) : 0;

    typedef struct packed {
        logic [CHAN_W-1:0] layer_strength;
        logic [CHAN_W-1:0] layer_red;
        logic [CHAN_W-1:0] layer_green;
        logic [CHAN_W-1:0] layer_blue;
        logic              last_layer;
    } ltc_layer_t;

    typedef struct packed {
        logic [OUT_W-1:0] blend_red;
        logic [OUT_W-1:0] blend_green;
        logic [OUT_W-1:0] blend_blue;
        logic [OUT_W-1:0] blend_alpha;
    } ltc_blend_t;

    typedef struct packed {
        logic            start;
        logic [A2_W-1:0] a2;
        logic [A2_W-1:0] a_new;
    } ltc_mix_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EST,
        ST_CHK,
        ST_FIX,
        ST_ALPHA,
        ST_ANEW,
        ST_MIX,
        ST_EMIT1,
        ST_EMIT2
    } ltc_state_t;

    // running color to Q8.16
    function automatic logic [Q16_W-1:0] to_q16(input logic [COL_W-1:0] c);
        logic [COL_W+SH_UP-1:0] t;
        t = (COL_W + SH_UP)'(c) << SH_UP;
        return Q16_W'(t >> SH_DN);
    endfunction

    // running alpha to Q1.16
    function automatic logic [OUT_W:0] to_a16(input logic [A2_W-1:0] a);
        logic [A2_W+SH_UP-1:0] t;
        t = (A2_W + SH_UP)'(a) << SH_UP;
        return (OUT_W + 1)'(t >> SH_DN);
    endfunction

endpackage

`default_nettype wire

@@ src/ltc_mix_unit.sv @@
//------------------------------------------------------------------------------
// ltc_mix_unit
// Bit-serial restoring divider for the color weight, with the three color
// channels accumulated one weight bit per cycle, msb first.
//------------------------------------------------------------------------------
`default_nettype none

module ltc_mix_unit (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  ltc_pkg::ltc_mix_cmd_t                         cmd,
    input  logic [2:0][ltc_pkg::CHAN_W-1:0]               col,
    input  logic [2:0][ltc_pkg::COL_W-1:0]                cin,
    output logic [2:0][ltc_pkg::COL_W-1:0]                cout,
    output logic                                          done
);

    logic                                 busy_reg;
    logic [ltc_pkg::CNT_W-1:0]            cnt_reg;
    logic                                 done_reg;
    logic [ltc_pkg::A2_W-1:0]             rem_reg;
    logic [ltc_pkg::A2_W-1:0]             div_reg;
    logic signed [ltc_pkg::D_W-1:0]       d_reg   [3];
    logic signed [ltc_pkg::ACC_W-1:0]     acc_reg [3];
    logic [2:0][ltc_pkg::COL_W-1:0]       c_reg;
    logic [2:0][ltc_pkg::COL_W-1:0]       cout_reg;

    logic                                 q_bit;
    logic                                 last_step;
    logic [ltc_pkg::A2_W-1:0]             rem_diff;
    logic [ltc_pkg::A2_W-1:0]             rem_next;
    logic signed [ltc_pkg::ACC_W-1:0]     acc_next [3];
    logic signed [ltc_pkg::ACC_W-1:0]     sum      [3];
    logic [2:0][ltc_pkg::COL_W-1:0]       c_new;

    always_comb
    begin
        q_bit     = rem_reg >= div_reg;
        rem_diff  = q_bit ? (rem_reg - div_reg) : rem_reg;
        rem_next  = ltc_pkg::A2_W'({rem_diff, 1'b0});
        last_step = cnt_reg == ltc_pkg::CNT_W'(1);
        for (int ch = 0; ch < 3; ch++)
        begin
            acc_next[ch] = (acc_reg[ch] <<< 1)
                         + (q_bit ? ltc_pkg::ACC_W'(d_reg[ch]) : {ltc_pkg::ACC_W{1'b0}});
            sum[ch]      = $signed(ltc_pkg::ACC_W'(c_reg[ch]) << ltc_pkg::FRAC_BITS)
                         + acc_next[ch];
            c_new[ch]    = sum[ch][ltc_pkg::FRAC_BITS +: ltc_pkg::COL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !cmd.start && busy_reg && last_step;
            if (cmd.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= ltc_pkg::CNT_W'(ltc_pkg::A2_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - ltc_pkg::CNT_W'(1);
                if (last_step)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            rem_reg <= cmd.a2;
            div_reg <= cmd.a_new;
            c_reg   <= cin;
            for (int ch = 0; ch < 3; ch++)
            begin
                d_reg[ch]   <= $signed(ltc_pkg::D_W'(col[ch]) << ltc_pkg::FRAC_BITS)
                             - $signed(ltc_pkg::D_W'(cin[ch]));
                acc_reg[ch] <= '0;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            for (int ch = 0; ch < 3; ch++)
            begin
                acc_reg[ch] <= acc_next[ch];
            end
            if (last_step)
            begin
                cout_reg <= c_new;
            end
        end
    end

    assign cout = cout_reg;
    assign done = done_reg;

endmodule

`default_nettype wire

@@ src/layered_tint_compositor_top.sv @@
//------------------------------------------------------------------------------
// layered_tint_compositor_top
// Front-to-back compositing of tint layers into a running color and alpha.
// Tint layer: after accept the FSM passes EST, CHK, FIX, ALPHA and ANEW,
// then waits in MIX for the 17-step bit-serial weight divider in the mix unit.
// Skipped layer (zero alpha): back to idle from FIX. Closing layer: result
// registered through EMIT1 and EMIT2, where it waits while the output stalls.
// Reset clears running color and alpha and sets global percent to 100.
//------------------------------------------------------------------------------
`default_nettype none

module layered_tint_compositor_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ltc_pkg::ltc_layer_t          layer,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ltc_pkg::ltc_blend_t          blend,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [ltc_pkg::PCT_W-1:0]    cfg_data
);

    ltc_pkg::ltc_state_t                  state_reg;
    ltc_pkg::ltc_state_t                  state_next;
    logic [ltc_pkg::PCT_W-1:0]            pct_reg;
    ltc_pkg::ltc_layer_t                  layer_reg;
    logic [ltc_pkg::P_W-1:0]              prod_reg;
    logic [ltc_pkg::Q_W-1:0]              est_reg;
    logic [ltc_pkg::QM_W-1:0]             qm_reg;
    logic [ltc_pkg::A2_W-1:0]             a2_reg;
    logic [2*ltc_pkg::A2_W-1:0]           aprod_reg;
    logic [2:0][ltc_pkg::COL_W-1:0]       acc_col_reg;
    logic [ltc_pkg::A2_W-1:0]             acc_alpha_reg;
    logic [2:0][ltc_pkg::Q16_W-1:0]       emit_c16_reg;
    logic [2:0][ltc_pkg::OUT_W:0]         emit_est_reg;
    logic [ltc_pkg::OUT_W:0]              emit_a16_reg;
    ltc_pkg::ltc_blend_t                  out_reg;
    logic                                 out_valid_reg;

    logic [ltc_pkg::EMUL_W-1:0]           est_mul;
    logic [ltc_pkg::QM_W-1:0]             scale_rem;
    logic [ltc_pkg::Q_W-1:0]              a2_raw;
    logic [ltc_pkg::A2_W-1:0]             a2_calc;
    logic [ltc_pkg::A2_W-1:0]             a_new;
    logic [2:0][ltc_pkg::Q16_W-1:0]       c16;
    logic [2:0][ltc_pkg::Q16_W+8:0]       mul257;
    logic [2:0][ltc_pkg::Q16_W:0]         rem255;
    logic [2:0][ltc_pkg::OUT_W:0]         qfix;
    logic [2:0][ltc_pkg::OUT_W-1:0]       chan_out;
    logic [ltc_pkg::OUT_W-1:0]            alpha_out;
    logic                                 out_load;

    ltc_pkg::ltc_mix_cmd_t                mix_cmd;
    logic [2:0][ltc_pkg::CHAN_W-1:0]      mix_col;
    logic [2:0][ltc_pkg::COL_W-1:0]       mix_cout;
    logic                                 mix_done;

    assign mix_col = {layer_reg.layer_red, layer_reg.layer_green, layer_reg.layer_blue};

    ltc_mix_unit u_mix (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (mix_cmd),
        .col  (mix_col),
        .cin  (acc_col_reg),
        .cout (mix_cout),
        .done (mix_done)
    );

    // layer alpha by reciprocal with one correction step
    always_comb
    begin
        est_mul   = ltc_pkg::EMUL_W'(prod_reg) * ltc_pkg::EMUL_W'(ltc_pkg::SCALE_RECIP);
        scale_rem = (ltc_pkg::QM_W'(prod_reg) << ltc_pkg::FRAC_BITS) - qm_reg;
        a2_raw    = est_reg
                  + ltc_pkg::Q_W'(scale_rem >= ltc_pkg::QM_W'(ltc_pkg::SCALE_DEN));
        a2_calc   = (a2_raw > ltc_pkg::ONE_FX) ? ltc_pkg::ONE_FX : a2_raw;
        a_new     = ltc_pkg::A2_W'(acc_alpha_reg
                  + aprod_reg[ltc_pkg::FRAC_BITS +: ltc_pkg::A2_W]);
    end

    // divide by 255 via multiply by 257 and one correction
    always_comb
    begin
        for (int ch = 0; ch < 3; ch++)
        begin
            c16[ch]    = ltc_pkg::to_q16(acc_col_reg[ch]);
            mul257[ch] = ((ltc_pkg::Q16_W + 9)'(c16[ch]) << 8)
                       + (ltc_pkg::Q16_W + 9)'(c16[ch]);
            rem255[ch] = (ltc_pkg::Q16_W + 1)'(emit_c16_reg[ch])
                       + (ltc_pkg::Q16_W + 1)'(emit_est_reg[ch])
                       - ((ltc_pkg::Q16_W + 1)'(emit_est_reg[ch]) << 8);
            qfix[ch]   = emit_est_reg[ch]
                       + (ltc_pkg::OUT_W + 1)'(rem255[ch]
                         >= (ltc_pkg::Q16_W + 1)'(ltc_pkg::CHAN_MAX));
            chan_out[ch] = (qfix[ch] > (ltc_pkg::OUT_W + 1)'(ltc_pkg::OUT_MAX))
                         ? ltc_pkg::OUT_W'(ltc_pkg::OUT_MAX) : qfix[ch][ltc_pkg::OUT_W-1:0];
        end
        alpha_out = (emit_a16_reg > (ltc_pkg::OUT_W + 1)'(ltc_pkg::OUT_MAX))
                  ? ltc_pkg::OUT_W'(ltc_pkg::OUT_MAX) : emit_a16_reg[ltc_pkg::OUT_W-1:0];
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        mix_cmd.start = 1'b0;
        mix_cmd.a2    = a2_reg;
        mix_cmd.a_new = a_new;
        case (state_reg)
            ltc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = ltc_pkg::ST_EST;
                end
            end
            ltc_pkg::ST_EST:
            begin
                state_next = ltc_pkg::ST_CHK;
            end
            ltc_pkg::ST_CHK:
            begin
                state_next = ltc_pkg::ST_FIX;
            end
            ltc_pkg::ST_FIX:
            begin
                if (a2_calc == '0)
                begin
                    state_next = layer_reg.last_layer ? ltc_pkg::ST_EMIT1 : ltc_pkg::ST_IDLE;
                end
                else
                begin
                    state_next = ltc_pkg::ST_ALPHA;
                end
            end
            ltc_pkg::ST_ALPHA:
            begin
                state_next = ltc_pkg::ST_ANEW;
            end
            ltc_pkg::ST_ANEW:
            begin
                mix_cmd.start = 1'b1;
                state_next    = ltc_pkg::ST_MIX;
            end
            ltc_pkg::ST_MIX:
            begin
                if (mix_done)
                begin
                    state_next = layer_reg.last_layer ? ltc_pkg::ST_EMIT1 : ltc_pkg::ST_IDLE;
                end
            end
            ltc_pkg::ST_EMIT1:
            begin
                state_next = ltc_pkg::ST_EMIT2;
            end
            ltc_pkg::ST_EMIT2:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_load   = 1'b1;
                    state_next = ltc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ltc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ltc_pkg::ST_IDLE;
            pct_reg       <= ltc_pkg::PCT_RESET;
            acc_col_reg   <= '0;
            acc_alpha_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                pct_reg <= cfg_data;
            end
            if (state_reg == ltc_pkg::ST_ANEW)
            begin
                acc_alpha_reg <= a_new;
            end
            if (state_reg == ltc_pkg::ST_MIX && mix_done)
            begin
                acc_col_reg <= mix_cout;
            end
            if (state_reg == ltc_pkg::ST_EMIT1)
            begin
                acc_col_reg   <= '0;
                acc_alpha_reg <= '0;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            layer_reg <= layer;
            prod_reg  <= ltc_pkg::P_W'(layer.layer_strength) * ltc_pkg::P_W'(pct_reg);
        end
        if (state_reg == ltc_pkg::ST_EST)
        begin
            est_reg <= ltc_pkg::Q_W'(est_mul >> ltc_pkg::RECIP_SH);
        end
        if (state_reg == ltc_pkg::ST_CHK)
        begin
            qm_reg <= ltc_pkg::QM_W'(est_reg) * ltc_pkg::QM_W'(ltc_pkg::SCALE_DEN);
        end
        if (state_reg == ltc_pkg::ST_FIX)
        begin
            a2_reg <= a2_calc;
        end
        if (state_reg == ltc_pkg::ST_ALPHA)
        begin
            aprod_reg <= (2 * ltc_pkg::A2_W)'(a2_reg)
                       * (2 * ltc_pkg::A2_W)'(ltc_pkg::ONE_FX - acc_alpha_reg);
        end
        if (state_reg == ltc_pkg::ST_EMIT1)
        begin
            emit_c16_reg <= c16;
            emit_a16_reg <= ltc_pkg::to_a16(acc_alpha_reg);
            for (int ch = 0; ch < 3; ch++)
            begin
                emit_est_reg[ch] <= mul257[ch][ltc_pkg::Q16_W+8:16];
            end
        end
        if (out_load)
        begin
            out_reg.blend_red   <= chan_out[2];
            out_reg.blend_green <= chan_out[1];
            out_reg.blend_blue  <= chan_out[0];
            out_reg.blend_alpha <= alpha_out;
        end
    end

    assign out_valid = out_valid_reg;
    assign blend     = out_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ src/ltc_checker.sv @@
//------------------------------------------------------------------------------
// ltc_checker
// Port-level checks for the layered tint compositor, bound to the top level.
//------------------------------------------------------------------------------
`default_nettype none

module ltc_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input ltc_pkg::ltc_blend_t  blend
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(blend))
        else $error("result beat changed while stalled");

    // one layer at a time
    a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input ready right after an accepted beat");

    // a result never shows up on the cycle after a layer beat
    a_out_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result raised directly after a layer beat");

endmodule

bind layered_tint_compositor_top ltc_checker u_ltc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .blend    (blend)
);

`default_nettype wire
